// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, muted while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// File: rtl/sont_pkg.sv
// Types and constants shared by the slope onset note trigger modules.
package sont_pkg;

  // Slope sample width
  localparam int SAMPLE_BITS = 16;

  // Unity key-scale factor: 60 * 4096
  localparam logic signed [18:0] SCALE_ONE = 19'sd245760;
  localparam logic [7:0] NOTE_CENTER = 8'd60;

  // Key-scale factor width and scaled-threshold width
  localparam int SCALE_BITS = 24;
  localparam int THR_BITS = 16 + SCALE_BITS;

  // Compare width: wide enough for both threshold and scaled sample
  localparam int CMP_BITS = ((SAMPLE_BITS + 19) > THR_BITS) ?
                            (SAMPLE_BITS + 19 + 1) : (THR_BITS + 1);

  // Reset values of the registers
  localparam logic signed [15:0] ON_THRESHOLD_RST = 16'sd3277;
  localparam logic [14:0] OFF_THRESHOLD_RST = 15'd328;
  localparam logic signed [15:0] KEY_SCALING_RST = 16'sd0;
  localparam logic [6:0] NOTE_NUMBER_RST = 7'd60;
  localparam logic [15:0] HOLDOFF_BLOCKS_RST = 16'd4;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ON_THRESHOLD   = 3'd0,
    REG_OFF_THRESHOLD  = 3'd1,
    REG_KEY_SCALING    = 3'd2,
    REG_NOTE_NUMBER    = 3'd3,
    REG_HOLDOFF_BLOCKS = 3'd4
  } reg_index_t;

  // Event kinds
  typedef enum logic {
    EV_NOTE_OFF = 1'b0,
    EV_NOTE_ON  = 1'b1
  } ev_kind_t;

  // One result event
  typedef struct packed {
    ev_kind_t    kind;
    logic [6:0]  note;
    logic [31:0] onsets;
    logic        last;
  } event_t;

  // Settings handed from the register block to the decision stage
  typedef struct packed {
    logic signed [THR_BITS-1:0] on_prod;
    logic signed [THR_BITS-1:0] off_prod;
    logic [6:0]                 note;
    logic [15:0]                holdoff;
  } cfg_t;

  // Events pushed into the output queue in one cycle
  typedef struct packed {
    logic [1:0] num;
    event_t     first;
    event_t     second;
  } push_t;

  // Output queue status
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } q_stat_t;

endpackage

// File: rtl/sont_cfg.sv
// Configuration registers and registered key-scaled threshold products.
module sont_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output sont_pkg::cfg_t   cfg
);

  logic signed [15:0] on_threshold;
  logic [14:0]        off_threshold;
  logic signed [15:0] key_scaling;
  logic [6:0]         note_number;
  logic [15:0]        holdoff_blocks;

  logic signed [sont_pkg::SCALE_BITS-1:0] scale;
  logic signed [sont_pkg::SCALE_BITS-1:0] scale_next;
  logic signed [sont_pkg::THR_BITS-1:0]   on_prod;
  logic signed [sont_pkg::THR_BITS-1:0]   off_prod;

  logic signed [15:0] key_src;
  logic [6:0]         note_src;
  logic signed [7:0]  note_offs;
  logic signed [sont_pkg::SCALE_BITS-1:0] key_term;

  // Scale follows a write to key or note in the same edge
  always_comb begin
    key_src  = (cfg_write && cfg_index == sont_pkg::REG_KEY_SCALING) ?
               $signed(cfg_data) : key_scaling;
    note_src = (cfg_write && cfg_index == sont_pkg::REG_NOTE_NUMBER) ?
               cfg_data[6:0] : note_number;
    note_offs = $signed({1'b0, note_src} - sont_pkg::NOTE_CENTER);
    key_term  = sont_pkg::SCALE_BITS'(key_src) * sont_pkg::SCALE_BITS'(note_offs);
    scale_next = sont_pkg::SCALE_BITS'(sont_pkg::SCALE_ONE) + key_term;
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold   <= sont_pkg::ON_THRESHOLD_RST;
      off_threshold  <= sont_pkg::OFF_THRESHOLD_RST;
      key_scaling    <= sont_pkg::KEY_SCALING_RST;
      note_number    <= sont_pkg::NOTE_NUMBER_RST;
      holdoff_blocks <= sont_pkg::HOLDOFF_BLOCKS_RST;
      scale          <= sont_pkg::SCALE_BITS'(sont_pkg::SCALE_ONE);
    end else begin
      scale <= scale_next;
      if (cfg_write) begin
        case (cfg_index)
          sont_pkg::REG_ON_THRESHOLD:   on_threshold   <= $signed(cfg_data);
          sont_pkg::REG_OFF_THRESHOLD:  off_threshold  <= cfg_data[14:0];
          sont_pkg::REG_KEY_SCALING:    key_scaling    <= $signed(cfg_data);
          sont_pkg::REG_NOTE_NUMBER:    note_number    <= cfg_data[6:0];
          sont_pkg::REG_HOLDOFF_BLOCKS: holdoff_blocks <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Scaled threshold products, one multiply behind the scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      on_prod  <= sont_pkg::THR_BITS'(sont_pkg::ON_THRESHOLD_RST) *
                  sont_pkg::THR_BITS'(sont_pkg::SCALE_ONE);
      off_prod <= sont_pkg::THR_BITS'($signed({1'b0, sont_pkg::OFF_THRESHOLD_RST})) *
                  sont_pkg::THR_BITS'(sont_pkg::SCALE_ONE);
    end else begin
      on_prod  <= sont_pkg::THR_BITS'(on_threshold) * sont_pkg::THR_BITS'(scale);
      off_prod <= sont_pkg::THR_BITS'($signed({1'b0, off_threshold})) *
                  sont_pkg::THR_BITS'(scale);
    end
  end

  assign cfg.on_prod  = on_prod;
  assign cfg.off_prod = off_prod;
  assign cfg.note     = note_number;
  assign cfg.holdoff  = holdoff_blocks;

endmodule

// File: rtl/sont_core.sv
// Input register, peak and level decisions, and the trigger state.
module sont_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sont_pkg::SAMPLE_BITS-1:0] slope_sample,
  input  logic [14:0]                         block_level,
  input  logic                                end_of_block,
  input  sont_pkg::cfg_t                      cfg,
  input  sont_pkg::q_stat_t                   qstat,
  output sont_pkg::push_t                     push
);

  // Input register
  logic                                    s1_valid;
  logic signed [sont_pkg::SAMPLE_BITS-1:0] s1_slope;
  logic [14:0]                             s1_level;
  logic                                    s1_eob;

  // Trigger state
  logic signed [sont_pkg::SAMPLE_BITS-1:0] previous_slope;
  logic signed [sont_pkg::SAMPLE_BITS-1:0] candidate_slope;
  logic                                    cand_valid;
  logic                                    note_active;
  logic [31:0]                             block_index;
  logic [31:0]                             last_peak_block;
  logic [31:0]                             onset_total;

  logic signed [sont_pkg::CMP_BITS-1:0] cand_sc;
  logic signed [sont_pkg::CMP_BITS-1:0] level_sc;
  logic signed [sont_pkg::CMP_BITS-1:0] on_cmp;
  logic signed [sont_pkg::CMP_BITS-1:0] off_cmp;
  logic [31:0] hold_gap;
  logic        level_low;
  logic        off_level;
  logic        peak;
  logic        trig;
  logic        off_any;
  logic [1:0]  n_ev;
  logic [1:0]  space;
  logic        fire;
  logic        in_fire;
  sont_pkg::event_t off_ev;
  sont_pkg::event_t on_ev;

  // Decisions on the registered item
  always_comb begin
    cand_sc  = sont_pkg::CMP_BITS'(candidate_slope) *
               sont_pkg::CMP_BITS'(sont_pkg::SCALE_ONE);
    level_sc = sont_pkg::CMP_BITS'($signed({1'b0, s1_level})) *
               sont_pkg::CMP_BITS'(sont_pkg::SCALE_ONE);
    on_cmp   = sont_pkg::CMP_BITS'(cfg.on_prod);
    off_cmp  = sont_pkg::CMP_BITS'(cfg.off_prod);
    level_low = level_sc < off_cmp;
    off_level = note_active && level_low;
    peak = cand_valid && (cand_sc > on_cmp) &&
           (candidate_slope > previous_slope) && (candidate_slope > s1_slope);
    hold_gap = block_index - last_peak_block;
    trig = peak && (hold_gap > {16'd0, cfg.holdoff});
    // level note off, or retrigger note off of a still-active note
    off_any = off_level || (trig && note_active);
    n_ev = {1'b0, off_any} + {1'b0, trig};
  end

  // Events
  always_comb begin
    off_ev.kind   = sont_pkg::EV_NOTE_OFF;
    off_ev.note   = cfg.note;
    off_ev.onsets = onset_total;
    off_ev.last   = !trig;
    on_ev.kind    = sont_pkg::EV_NOTE_ON;
    on_ev.note    = cfg.note;
    on_ev.onsets  = onset_total + 32'd1;
    on_ev.last    = 1'b1;
  end

  // Queue room after this cycle's pop
  assign space    = 2'd2 - qstat.count + {1'b0, qstat.pop};
  assign fire     = s1_valid && (n_ev <= space);
  assign in_ready = !s1_valid || fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    push.num    = fire ? n_ev : 2'd0;
    push.first  = off_any ? off_ev : on_ev;
    push.second = on_ev;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slope <= slope_sample;
      s1_level <= block_level;
      s1_eob   <= end_of_block;
    end
  end

  // State update when the item's events go to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_slope  <= '0;
      candidate_slope <= '0;
      cand_valid      <= 1'b0;
      note_active     <= 1'b0;
      block_index     <= '0;
      last_peak_block <= '0;
      onset_total     <= '0;
    end else if (fire) begin
      previous_slope  <= candidate_slope;
      candidate_slope <= s1_slope;
      cand_valid      <= 1'b1;
      note_active     <= trig || (note_active && !level_low);
      if (trig) begin
        onset_total <= onset_total + 32'd1;
      end
      if (peak) begin
        last_peak_block <= block_index;
      end
      if (s1_eob) begin
        block_index <= block_index + 32'd1;
      end
    end
  end

endmodule

// File: rtl/sont_outq.sv
// Two-entry event queue feeding the result channel.
module sont_outq (
  input  logic               clk,
  input  logic               rst,
  input  sont_pkg::push_t    push,
  input  logic               out_ready,
  output logic               out_valid,
  output sont_pkg::event_t   head,
  output sont_pkg::q_stat_t  qstat
);

  sont_pkg::event_t q0;
  sont_pkg::event_t q1;
  sont_pkg::event_t q0_next;
  sont_pkg::event_t q1_next;
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] remain;
  logic       pop;

  assign out_valid   = (count != 2'd0);
  assign pop         = out_valid && out_ready;
  assign head        = q0;
  assign qstat.count = count;
  assign qstat.pop   = pop;

  // Shift on pop, then append pushed events behind what remains
  always_comb begin
    remain  = count - {1'b0, pop};
    q0_next = pop ? q1 : q0;
    q1_next = q1;
    case (remain)
      2'd0: begin
        if (push.num != 2'd0) begin
          q0_next = push.first;
        end
        if (push.num == 2'd2) begin
          q1_next = push.second;
        end
      end
      2'd1: begin
        if (push.num != 2'd0) begin
          q1_next = push.first;
        end
      end
      default: ;
    endcase
    count_next = remain + push.num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule

// File: rtl/slope_onset_note_trigger.sv
// Slope onset note trigger: takes one slope sample per cycle and issues note
// on and note off events. Throughput is one input transaction per clock while
// the event queue has room; an item is held in an input register and decided in
// the next cycle, so its first event is valid on the result port once the item's
// events have been pushed. An item that causes a note off and a note on puts
// both into a two-entry event queue and occupies the result port for both
// events; the input stalls only when that queue has no room. Each sample is
// judged as a peak when its right neighbour arrives. Register writes take
// effect for samples accepted after the write, once the key-scaled threshold
// products have been registered.
`include "assert_macros.svh"

module slope_onset_note_trigger (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [2:0]                              cfg_index,
  input  logic [15:0]                             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [sont_pkg::SAMPLE_BITS-1:0] slope_sample,
  input  logic [14:0]                             block_level,
  input  logic                                    end_of_block,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    event_kind,
  output logic [6:0]                              event_note,
  output logic [31:0]                             onsets_so_far,
  output logic                                    is_last
);

  sont_pkg::cfg_t    cfg;
  sont_pkg::push_t   push;
  sont_pkg::q_stat_t qstat;
  sont_pkg::event_t  head;

  sont_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sont_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .slope_sample (slope_sample),
    .block_level  (block_level),
    .end_of_block (end_of_block),
    .cfg          (cfg),
    .qstat        (qstat),
    .push         (push)
  );

  sont_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .qstat     (qstat)
  );

  assign event_kind    = head.kind;
  assign event_note    = head.note;
  assign onsets_so_far = head.onsets;
  assign is_last       = head.last;

  // A note on always closes the events of its sample
  `ASSERT_CLK(a_on_is_last, (out_valid && event_kind) |-> is_last, "note on not last")
  // A leading note off has its note on already queued behind it
  `ASSERT_CLK(a_pair_queued, (out_valid && !is_last) |-> (qstat.count == 2'd2), "pair split")
  // Queue never overfills
  `ASSERT_NEVER(a_q_overfill, qstat.count == 2'd3, "event queue overflow")

endmodule

// File: tb/slope_onset_note_trigger_checker.sv
// Checker for the slope onset note trigger: predicts note events and compares results.
`timescale 1ns / 100ps

module slope_onset_note_trigger_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [2:0]                              cfg_index,
  input  logic [15:0]                             cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [sont_pkg::SAMPLE_BITS-1:0] slope_sample,
  input  logic [14:0]                             block_level,
  input  logic                                    end_of_block,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic                                    event_kind,
  input  logic [6:0]                              event_note,
  input  logic [31:0]                             onsets_so_far,
  input  logic                                    is_last,
  output int                                      fail_count,
  output int                                      events_pending
);

  // Shadow copies of the configuration registers
  logic signed [15:0] on_thr;
  logic [14:0]        off_thr;
  logic signed [15:0] key_scale;
  logic [6:0]         note_num;
  logic [15:0]        holdoff;

  // Trigger state: neighbors of the sample under judgement, note and block tracking
  logic signed [sont_pkg::SAMPLE_BITS-1:0] left_slope;
  logic signed [sont_pkg::SAMPLE_BITS-1:0] cand_slope;
  logic [1:0]                              taken;
  logic                                    sounding;
  logic [31:0]                             block_count;
  logic [31:0]                             peak_block;
  logic [31:0]                             onset_count;

  // Note events still owed by the block, oldest first
  sont_pkg::event_t expected_events[$];

  // Work out the events that one accepted sample causes
  task automatic predict_events(input logic signed [sont_pkg::SAMPLE_BITS-1:0] slope,
                                input logic [14:0] level, input logic eob);
    longint           scale;
    sont_pkg::event_t evs [2];
    int               n;
    logic [31:0]      since_peak;
    n = 0;
    scale = longint'(sont_pkg::SCALE_ONE) +
            longint'(key_scale) * (longint'(note_num) - longint'(sont_pkg::NOTE_CENTER));

    // Level drop ends a sounding note
    if (sounding && longint'(level) * longint'(sont_pkg::SCALE_ONE) <
                    longint'(off_thr) * scale) begin
      sounding = 1'b0;
      evs[n] = '{kind: sont_pkg::EV_NOTE_OFF, note: note_num, onsets: onset_count,
                 last: 1'b0};
      n++;
    end

    // Judge the waiting sample now that its right neighbor is here
    if (taken != 2'd0 && cand_slope > left_slope && cand_slope > slope &&
        longint'(cand_slope) * longint'(sont_pkg::SCALE_ONE) >
        longint'(on_thr) * scale) begin
      since_peak = block_count - peak_block;
      if (since_peak > 32'(holdoff)) begin
        if (sounding) begin
          evs[n] = '{kind: sont_pkg::EV_NOTE_OFF, note: note_num, onsets: onset_count,
                     last: 1'b0};
          n++;
        end
        sounding = 1'b1;
        onset_count = onset_count + 32'd1;
        evs[n] = '{kind: sont_pkg::EV_NOTE_ON, note: note_num, onsets: onset_count,
                   last: 1'b0};
        n++;
      end
      peak_block = block_count;
    end

    // Shift the stream and close the block
    left_slope = cand_slope;
    cand_slope = slope;
    if (taken != 2'd2) taken = taken + 2'd1;
    if (eob) block_count = block_count + 32'd1;

    if (n > 0) evs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_events.push_back(evs[i]);
  endtask

  always @(posedge clk) begin : watch
    sont_pkg::event_t want;
    if (rst) begin
      on_thr      = sont_pkg::ON_THRESHOLD_RST;
      off_thr     = sont_pkg::OFF_THRESHOLD_RST;
      key_scale   = sont_pkg::KEY_SCALING_RST;
      note_num    = sont_pkg::NOTE_NUMBER_RST;
      holdoff     = sont_pkg::HOLDOFF_BLOCKS_RST;
      left_slope  = '0;
      cand_slope  = '0;
      taken       = '0;
      sounding    = 1'b0;
      block_count = '0;
      peak_block  = '0;
      onset_count = '0;
      fail_count  = 0;
      expected_events.delete();
    end else begin
      // Register writes, out-of-range indexes are dropped
      if (cfg_write) begin
        case (cfg_index)
          sont_pkg::REG_ON_THRESHOLD:   on_thr    = cfg_data;
          sont_pkg::REG_OFF_THRESHOLD:  off_thr   = cfg_data[14:0];
          sont_pkg::REG_KEY_SCALING:    key_scale = cfg_data;
          sont_pkg::REG_NOTE_NUMBER:    note_num  = cfg_data[6:0];
          sont_pkg::REG_HOLDOFF_BLOCKS: holdoff   = cfg_data;
          default: ;
        endcase
      end

      // Input transaction
      if (in_valid && in_ready) predict_events(slope_sample, block_level, end_of_block);

      // Result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected event kind=%0d note=%0d onsets=%0d last=%0d",
                     $time, event_kind, event_note, onsets_so_far, is_last);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind || event_note !== want.note ||
              onsets_so_far !== want.onsets || is_last !== want.last) begin
            if (fail_count < 10)
              $display("%0t: event mismatch: expected kind=%0d note=%0d onsets=%0d last=%0d,%s",
                       $time, want.kind, want.note, want.onsets, want.last, "");
            if (fail_count < 10)
              $display("         got kind=%0d note=%0d onsets=%0d last=%0d",
                       event_kind, event_note, onsets_so_far, is_last);
            fail_count++;
          end
        end
      end
    end
    events_pending = expected_events.size();
  end

endmodule

// File: tb/slope_onset_note_trigger_tb.sv
// Testbench top for the slope onset note trigger: stimulus, idling and verdict.
`timescale 1ns / 100ps

module slope_onset_note_trigger_tb;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_PHASE  = 6;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] on_thr;
    logic [14:0]        off_thr;
    logic signed [15:0] key_scale;
    logic [6:0]         note;
    logic [15:0]        holdoff;
  } settings_t;

  logic                                    clk;
  logic                                    rst          = 1'b1;
  logic                                    cfg_write    = 1'b0;
  logic [2:0]                              cfg_index    = '0;
  logic [15:0]                             cfg_data     = '0;
  logic                                    in_valid     = 1'b0;
  logic                                    in_ready;
  logic signed [sont_pkg::SAMPLE_BITS-1:0] slope_sample = '0;
  logic [14:0]                             block_level  = '0;
  logic                                    end_of_block = 1'b0;
  logic                                    out_valid;
  logic                                    out_ready    = 1'b0;
  logic                                    event_kind;
  logic [6:0]                              event_note;
  logic [31:0]                             onsets_so_far;
  logic                                    is_last;

  int fail_count;
  int events_pending;

  // Stimulus shaping and idling controls
  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  int     phase_num     = -1;
  int     phase_items   = 0;
  int     hold_left     = 0;
  bit     hold_done     = 1'b0;
  longint on_mark       = 0;
  longint off_mark      = 0;
  int     cycle_count   = 0;

  slope_onset_note_trigger i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .slope_sample  (slope_sample),
    .block_level   (block_level),
    .end_of_block  (end_of_block),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .event_note    (event_note),
    .onsets_so_far (onsets_so_far),
    .is_last       (is_last)
  );

  slope_onset_note_trigger_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .slope_sample   (slope_sample),
    .block_level    (block_level),
    .end_of_block   (end_of_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .event_note     (event_note),
    .onsets_so_far  (onsets_so_far),
    .is_last        (is_last),
    .fail_count     (fail_count),
    .events_pending (events_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase_num == HOLD_PHASE && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic signed [15:0] clip_slope(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic [14:0] clip_level(longint v);
    if (v > 32767) return 15'h7FFF;
    if (v < 0) return 15'h0000;
    return 15'(v);
  endfunction

  // Levels mostly hold a note, some sit on the note-off threshold
  function automatic logic [14:0] pick_level();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return clip_level(off_mark + int'($urandom_range(1, 4000)));
      6, 7:             return clip_level(off_mark + int'($urandom_range(0, 8)) - 4);
      8:                return 15'($urandom);
      default:          return ($urandom_range(0, 1) != 0) ? 15'h7FFF : 15'h0000;
    endcase
  endfunction

  // One input transaction, with random idle cycles ahead of it
  task automatic send_sample(input logic signed [15:0] slope, input logic [14:0] level,
                             input logic eob);
    logic took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    slope_sample <= slope;
    block_level  <= level;
    end_of_block <= eob;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    phase_items++;
  endtask

  // Quiet stretch then a rise, crest and fall; now and then raw noise instead
  task automatic play_phrase();
    logic signed [15:0] crest;
    int                 quiet_len;
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 4)) send_sample(16'($urandom), 15'($urandom), 1'($urandom));
    end else begin
      quiet_len = $urandom_range(0, 10);
      repeat (quiet_len)
        send_sample(clip_slope(on_mark - int'($urandom_range(0, 3000))), pick_level(),
                    $urandom_range(0, 99) < 35);
      crest = clip_slope(on_mark + int'($urandom_range(1, 6000)));
      send_sample(clip_slope(crest - int'($urandom_range(1, 3000))), pick_level(),
                  $urandom_range(0, 99) < 35);
      send_sample(crest, pick_level(), $urandom_range(0, 99) < 35);
      send_sample(clip_slope(crest - int'($urandom_range(0, 3000))), pick_level(),
                  $urandom_range(0, 99) < 35);
    end
  endtask

  // Wait until every owed event has arrived, then let in-flight samples finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (events_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all registers (with junk above the narrow ones) and one unused index
  task automatic load_settings(input settings_t s);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    longint      scale;
    idx[0] = sont_pkg::REG_ON_THRESHOLD;   val[0] = s.on_thr;
    idx[1] = sont_pkg::REG_OFF_THRESHOLD;  val[1] = {1'($urandom), s.off_thr};
    idx[2] = sont_pkg::REG_KEY_SCALING;    val[2] = s.key_scale;
    idx[3] = sont_pkg::REG_NOTE_NUMBER;    val[3] = {9'($urandom), s.note};
    idx[4] = sont_pkg::REG_HOLDOFF_BLOCKS; val[4] = s.holdoff;
    idx[5] = 3'($urandom_range(int'(sont_pkg::REG_HOLDOFF_BLOCKS) + 1, 7));
    val[5] = 16'($urandom);
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
    // Approximate scaled thresholds, used only to shape stimulus
    scale = longint'(sont_pkg::SCALE_ONE) +
            longint'(s.key_scale) * (longint'(s.note) - longint'(sont_pkg::NOTE_CENTER));
    on_mark  = longint'(s.on_thr) * scale / longint'(sont_pkg::SCALE_ONE);
    off_mark = longint'(s.off_thr) * scale / longint'(sont_pkg::SCALE_ONE);
  endtask

  initial begin : stimulus
    settings_t s;
    int        p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: stream start with extremes, a crest held back by the holdoff
    send_sample(16'sh7FFF, 15'h7FFF, 1'b0);
    send_sample(16'sh8000, 15'h7FFF, 1'b1);
    repeat (4) send_sample(16'sh0000, 15'h7FFF, 1'b1);
    // Sample equal to the threshold is no peak, one above it triggers a note on
    send_sample(16'sd3277, 15'h7FFF, 1'b0);
    send_sample(16'sd3278, 15'h7FFF, 1'b0);
    send_sample(16'sh0000, 15'h7FFF, 1'b1);
    repeat (5) send_sample(16'sh0000, 15'h7FFF, 1'b1);
    // Flat top never peaks; the next crest retriggers: note off then note on
    send_sample(16'sd20000, 15'h7FFF, 1'b0);
    send_sample(16'sd20000, 15'h7FFF, 1'b0);
    send_sample(-16'sd1, 15'h7FFF, 1'b0);
    send_sample(16'sd30000, 15'h7FFF, 1'b0);
    send_sample(16'sh0000, 15'h7FFF, 1'b0);
    repeat (5) send_sample(16'sh0000, 15'h7FFF, 1'b1);
    // Level drop and retrigger on the same sample, then a drop just under threshold
    send_sample(16'sd9000, 15'h7FFF, 1'b0);
    send_sample(16'sh0000, 15'h0000, 1'b0);
    send_sample(16'sh0000, 15'd327, 1'b0);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: s = '{sont_pkg::ON_THRESHOLD_RST, sont_pkg::OFF_THRESHOLD_RST,
                 sont_pkg::KEY_SCALING_RST, sont_pkg::NOTE_NUMBER_RST,
                 sont_pkg::HOLDOFF_BLOCKS_RST};
        1: s = '{16'sh7FFF, 15'h7FFF, 16'sh8000, 7'h7F, 16'h0000};
        3: s = '{16'sh8000, 15'h0000, 16'sh7FFF, 7'h00, 16'hFFFF};
        HOLD_PHASE: s = '{16'sd2000, 15'd500, 16'sd0, 7'd64, 16'd1};
        default: begin
          s.on_thr = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 12000));
          s.off_thr = 15'($urandom_range(0, 4000));
          case ($urandom_range(0, 3))
            0:       s.key_scale = 16'sd0;
            1:       s.key_scale = 16'($urandom);
            default: s.key_scale = 16'(int'($urandom_range(0, 2400)) - 1200);
          endcase
          s.note    = 7'($urandom_range(0, 127));
          s.holdoff = 16'($urandom_range(0, 5));
        end
      endcase
      load_settings(s);

      // Idling mix rotates: none, sender idle, receiver stall, both
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 66; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 66; end
        default: begin send_idle_pct = 36; stall_pct <= 36; end
      endcase
      phase_num <= p;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) play_phrase();
      wait_idle();
    end

    // Drain with the receiver always ready so any extra event shows up
    stall_pct <= 0;
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && events_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/sont_pkg.sv
rtl/sont_cfg.sv
rtl/sont_core.sv
rtl/sont_outq.sv
rtl/slope_onset_note_trigger.sv
tb/slope_onset_note_trigger_checker.sv
tb/slope_onset_note_trigger_tb.sv
